// ===== hw/rtl/rsw_pkg.sv =====
// ============================================================================
// Region stopwatch table package
// Shared constants, field widths, entry layout and controller types.
// ============================================================================
package rsw_pkg;

    localparam int NUM_REGIONS = 64;
    localparam int ENTRIES     = NUM_REGIONS + 1;
    localparam int ADDR_W      = $clog2(ENTRIES);

    localparam int MODE_W  = 2;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 64;
    localparam int COUNT_W = 32;

    // Stored entry: start time, total time, enter count and running flag.
    localparam int ENTRY_W = TIME_W + TIME_W + COUNT_W + 1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 104;

    localparam logic [MODE_W-1:0] MODE_ENTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [ADDR_W-1:0] SPARE_INDEX = ADDR_W'(NUM_REGIONS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic capture;   // Accept an event and start the entry read.
        logic load;      // Read data is present; take the entry and the elapsed time.
        logic update;    // Write the entry back and load the result register.
    } ctrl_cmd_t;

    typedef struct packed {
        logic                 running;
        logic [COUNT_W-1:0]   count;
        logic [TIME_W-1:0]    total;
        logic [TIME_W-1:0]    start;
    } entry_t;

endpackage

// ===== hw/rtl/rsw_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module rsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rsw_ctrl.sv =====
// ============================================================================
// Region stopwatch table controller
// Sequences each event through read, load and update, and owns the handshakes.
// ============================================================================
module rsw_ctrl
    import rsw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.load    = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.update) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.load)
        else $error("accepted beat was not followed by the load step");

    a_update_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_tvalid)
        else $error("update did not present a result");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.load, cmd.update}))
        else $error("more than one datapath command at once");

    a_stall_holds_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && m_tvalid && !m_tready) |=> (state_reg == ST_UPDATE))
        else $error("update left while the result register was still full");

endmodule

// ===== hw/rtl/rsw_datapath.sv =====
// ============================================================================
// Region stopwatch table datapath
// Entry store, elapsed-time subtract, saturating update and result register.
// ============================================================================
module rsw_datapath
    import rsw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    input  logic [MODE_W-1:0]    in_mode,
    input  logic [ID_W-1:0]      in_region_id,
    input  logic [TIME_W-1:0]    in_timestamp,
    output logic [TIME_W-1:0]    out_total_us,
    output logic [COUNT_W-1:0]   out_enter_count,
    output logic                 out_running,
    output logic                 out_used_spare
);

    logic                spare;
    logic [ADDR_W-1:0]   rd_index;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0]  ram_wdata;
    entry_t              rd_entry;
    entry_t              new_entry;

    logic [MODE_W-1:0]   mode_reg;
    logic [ADDR_W-1:0]   index_reg;
    logic                spare_reg;
    logic [TIME_W-1:0]   now_reg;
    entry_t              cur_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [TIME_W-1:0]   elapsed_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;

    logic [TIME_W:0]     total_sum;
    logic [TIME_W-1:0]   out_total_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_running_reg;
    logic                out_spare_reg;

    assign spare    = in_region_id >= ID_W'(NUM_REGIONS);
    assign rd_index = spare ? SPARE_INDEX : in_region_id[ADDR_W-1:0];

    rsw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (index_reg),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (rd_index),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as all zeros.
    assign rd_entry = valid_reg[index_reg] ? entry_t'(ram_rdata) : '0;

    always_comb begin
        if (now_reg >= rd_entry.start) begin
            elapsed_next = now_reg - rd_entry.start;
        end else begin
            elapsed_next = '0;
        end
    end

    assign total_sum = {1'b0, cur_reg.total} + {1'b0, elapsed_reg};

    always_comb begin
        new_entry = cur_reg;
        if (mode_reg == MODE_ENTER && !cur_reg.running) begin
            new_entry.start   = now_reg;
            new_entry.running = 1'b1;
            if (cur_reg.count != '1) begin
                new_entry.count = cur_reg.count + COUNT_W'(1);
            end
        end else if (mode_reg == MODE_LEAVE && cur_reg.running) begin
            new_entry.total   = total_sum[TIME_W] ? '1 : total_sum[TIME_W-1:0];
            new_entry.running = 1'b0;
        end
    end

    assign ram_wdata = ENTRY_W'(new_entry);

    always_comb begin
        valid_next = valid_reg;
        if (cmd.update) begin
            valid_next[index_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            index_reg <= rd_index;
            spare_reg <= spare;
            now_reg   <= in_timestamp;
        end
        if (cmd.load) begin
            cur_reg     <= rd_entry;
            elapsed_reg <= elapsed_next;
        end
        if (cmd.update) begin
            out_total_reg   <= new_entry.total;
            out_count_reg   <= new_entry.count;
            out_running_reg <= new_entry.running;
            out_spare_reg   <= spare_reg;
        end
    end

    assign out_total_us    = out_total_reg;
    assign out_enter_count = out_count_reg;
    assign out_running     = out_running_reg;
    assign out_used_spare  = out_spare_reg;

endmodule

// ===== hw/rtl/region_stopwatch_table_core.sv =====
// ============================================================================
// Region stopwatch table core
// Per-region stopwatches driven by enter, leave and read events.
// ============================================================================
// Each input beat is one event: the mode on s_tuser, the region id and the
// current time in microseconds on s_tdata. Ids at or beyond NUM_REGIONS
// share one spare entry. Every event returns one result beat on m_tdata with
// the entry's total time, enter count and running flag after the event;
// m_tuser flags that the spare entry served it.
// An event passes through the entry read from the store, the elapsed-time
// subtract, and the saturating update with write-back. The update loads
// the result register and waits while the last result is not yet taken;
// a new event is accepted only once the previous one has finished.
// The result sits in an output register; while the receiver stalls, the next
// event is still accepted and carried up to its update, where it waits.
// Reset clears all entries at once through per-entry valid bits, so the block
// accepts events as soon as reset is released.
// ============================================================================
module region_stopwatch_table_core
    import rsw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // region_id[15:0], timestamp[79:16]
    input  logic [MODE_W-1:0]     s_tuser,   // mode[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // total_us[63:0], enter_count[95:64],
                                             // running[96], zeros[103:97]
    output logic                  m_tuser    // used_spare[0]
);

    ctrl_cmd_t           cmd;
    logic [TIME_W-1:0]   total_us;
    logic [COUNT_W-1:0]  enter_count;
    logic                running;

    rsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rsw_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .in_mode         (s_tuser),
        .in_region_id    (s_tdata[ID_W-1:0]),
        .in_timestamp    (s_tdata[ID_W+TIME_W-1:ID_W]),
        .out_total_us    (total_us),
        .out_enter_count (enter_count),
        .out_running     (running),
        .out_used_spare  (m_tuser)
    );

    assign m_tdata = {(M_TDATA_W-TIME_W-COUNT_W-1)'(0), running, enter_count, total_us};

endmodule
